// ----- rtl/deq_pkg.sv -----
// Shared types and constants for the double-ended queue.
// Used by deq_ctrl, deq_datapath and double_ended_queue; no dependencies.
`default_nettype none

package deq_pkg;

  localparam int DEQ_CAPACITY   = 1024;
  localparam int DEQ_DATA_WIDTH = 32;

  typedef enum logic [3:0] {
    ACT_PUSH_BACK  = 4'd0,
    ACT_PUSH_FRONT = 4'd1,
    ACT_POP_BACK   = 4'd2,
    ACT_POP_FRONT  = 4'd3,
    ACT_READ       = 4'd4,
    ACT_WRITE      = 4'd5,
    ACT_INSERT     = 4'd6,
    ACT_ERASE      = 4'd7,
    ACT_CLEAR      = 4'd8
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;         // capture the input transaction
    logic rd_en;        // read the element store
    logic rd_shift;     // read address from the shift source
    logic wr_en;        // write the element store
    logic wr_cursor;    // write address from the shift cursor
    logic wr_from_mem;  // write data from the registered read data
    logic cur_init;     // start the shift cursor
    logic cur_step;     // advance the shift cursor
    logic commit;       // update pointers and load the result register
  } deq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_t act;
    logic    fail;
    logic    shift_last;
    logic    out_free;
  } deq_sts_t;

endpackage

`default_nettype wire

// ----- rtl/deq_datapath.sv -----
// Datapath of the double-ended queue: element store, head pointer, count,
// shift cursor and result register. Depends on deq_pkg.
`default_nettype none

module deq_datapath import deq_pkg::*; #(
  parameter int CAPACITY   = DEQ_CAPACITY,
  parameter int DATA_WIDTH = DEQ_DATA_WIDTH,
  localparam int PW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire deq_cmd_t              cmd,
  output deq_sts_t                   sts,
  input  wire logic [3:0]            action,
  input  wire logic [DATA_WIDTH-1:0] data_in,
  input  wire logic [PW-1:0]         position,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [DATA_WIDTH-1:0]      read_data,
  output logic [1:0]                 status,
  output logic [CW-1:0]              element_count
);

  localparam int SW = CW + 1;

  action_t               act_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [PW-1:0]         pos_q;
  logic [PW-1:0]         head;
  logic [CW-1:0]         count;
  logic [CW-1:0]         cursor;
  logic [DATA_WIDTH-1:0] mem_q;
  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [PW-1:0]         head_next;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         pos_ext;
  logic [CW-1:0]         direct_idx;
  logic [CW-1:0]         src_idx;
  logic [PW-1:0]         head_dec;
  logic [PW-1:0]         head_inc;
  logic [PW-1:0]         rd_addr;
  logic [PW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_value;
  logic                  count_full;
  status_t               st;

  // Physical slot of a logical index: head plus index, wrapped once.
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] hd,
                                            input logic [CW-1:0] idx);
    logic [SW-1:0] sum;
    sum = SW'(hd) + SW'(idx);
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[PW-1:0];
  endfunction

  assign pos_ext    = CW'(pos_q);
  assign count_full = (count == CW'(CAPACITY));
  assign head_dec   = (head == '0) ? PW'(CAPACITY - 1) : head - PW'(1);
  assign head_inc   = (head == PW'(CAPACITY - 1)) ? '0 : head + PW'(1);
  assign src_idx    = (act_q == ACT_INSERT) ? cursor - CW'(1) : cursor + CW'(1);

  always_comb begin
    case (act_q)
      ACT_PUSH_BACK: direct_idx = count;
      ACT_POP_BACK:  direct_idx = count - CW'(1);
      ACT_POP_FRONT: direct_idx = '0;
      default:       direct_idx = pos_ext;
    endcase
  end

  always_comb begin
    case (act_q) inside
      ACT_PUSH_BACK, ACT_PUSH_FRONT: st = count_full ? ST_FULL : ST_OK;
      ACT_POP_BACK, ACT_POP_FRONT:   st = (count == '0) ? ST_RANGE : ST_OK;
      ACT_READ, ACT_WRITE, ACT_ERASE: st = (pos_ext >= count) ? ST_RANGE : ST_OK;
      ACT_INSERT: begin
        if (pos_ext > count) begin
          st = ST_RANGE;
        end else if (count_full) begin
          st = ST_FULL;
        end else begin
          st = ST_OK;
        end
      end
      default: st = ST_OK;
    endcase
  end

  assign rd_addr = cmd.rd_shift ? slot_of(head, src_idx) : slot_of(head, direct_idx);
  assign wr_addr = cmd.wr_cursor ? slot_of(head, cursor) :
                   (act_q == ACT_PUSH_FRONT) ? head_dec : slot_of(head, direct_idx);
  assign wr_data = cmd.wr_from_mem ? mem_q : data_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_comb begin
    head_next  = head;
    count_next = count;
    rd_value   = '0;
    if (st == ST_OK) begin
      case (act_q)
        ACT_PUSH_BACK: count_next = count + CW'(1);
        ACT_PUSH_FRONT: begin
          head_next  = head_dec;
          count_next = count + CW'(1);
        end
        ACT_POP_BACK: begin
          count_next = count - CW'(1);
          rd_value   = mem_q;
        end
        ACT_POP_FRONT: begin
          head_next  = head_inc;
          count_next = count - CW'(1);
          rd_value   = mem_q;
        end
        ACT_READ:   rd_value = mem_q;
        ACT_INSERT: count_next = count + CW'(1);
        ACT_ERASE:  count_next = count - CW'(1);
        ACT_CLEAR: begin
          head_next  = '0;
          count_next = '0;
        end
        default: ;
      endcase
    end
  end

  // Transaction capture and shift cursor
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q  <= action_t'(action);
      data_q <= data_in;
      pos_q  <= position;
    end
    if (cmd.cur_init) begin
      cursor <= (act_q == ACT_INSERT) ? count : pos_ext;
    end else if (cmd.cur_step) begin
      cursor <= src_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      head      <= head_next;
      count     <= count_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      read_data     <= rd_value;
      status        <= st;
      element_count <= count_next;
    end
  end

  assign sts.act        = act_q;
  assign sts.fail       = (st != ST_OK);
  assign sts.shift_last = (act_q == ACT_INSERT) ? (cursor == pos_ext)
                          : ((SW'(cursor) + SW'(1)) >= SW'(count));
  assign sts.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- rtl/deq_ctrl.sv -----
// Controller of the double-ended queue: sequences decode, memory access,
// element shifting and result hand-off. Depends on deq_pkg.
`default_nettype none

module deq_ctrl import deq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire deq_sts_t sts,
  output deq_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DECODE   = 5'b00010,
    S_SHIFT_RD = 5'b00100,
    S_SHIFT_WR = 5'b01000,
    S_RESP     = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE) || ((state == S_RESP) && sts.out_free);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_RESP;
        if (!sts.fail) begin
          case (sts.act) inside
            ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_WRITE: cmd.wr_en = 1'b1;
            ACT_POP_BACK, ACT_POP_FRONT, ACT_READ:    cmd.rd_en = 1'b1;
            ACT_INSERT, ACT_ERASE: begin
              cmd.cur_init = 1'b1;
              state_next   = S_SHIFT_RD;
            end
            default: ;
          endcase
        end
      end
      S_SHIFT_RD: begin
        if (sts.shift_last) begin
          // Insert drops the new element into the opened slot
          if (sts.act == ACT_INSERT) begin
            cmd.wr_en     = 1'b1;
            cmd.wr_cursor = 1'b1;
          end
          state_next = S_RESP;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_shift = 1'b1;
          state_next   = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_cursor   = 1'b1;
        cmd.wr_from_mem = 1'b1;
        cmd.cur_step    = 1'b1;
        state_next      = S_SHIFT_RD;
      end
      S_RESP: begin
        // Hold until the result register is free
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = S_DECODE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/double_ended_queue.sv -----
// Top level of the bounded double-ended queue held as a ring buffer.
// Instantiates deq_ctrl and deq_datapath; depends on deq_pkg.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------
//   input    | in_valid / in_ready | action, data_in, position
//   output   | out_valid/out_ready | read_data, status, element_count
//
// Push, pop, read, write, clear and any failed transaction pass through a
// decode state, which does any access to the single-port-write element store,
// and a commit state. Insert and erase add a read state and a write state per
// element moved, since each move is a read then a write through the same
// store, and a last read state closes the shift.
// Reset (rst, synchronous) empties the queue; store contents are left as is.
// A result waits in the output register; one more transaction is taken and
// held before its commit until that register frees up.
`default_nettype none

module double_ended_queue import deq_pkg::*; #(
  parameter int CAPACITY   = DEQ_CAPACITY,
  parameter int DATA_WIDTH = DEQ_DATA_WIDTH,
  localparam int PW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [3:0]            action,
  input  wire logic [DATA_WIDTH-1:0] data_in,
  input  wire logic [PW-1:0]         position,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [DATA_WIDTH-1:0]      read_data,
  output logic [1:0]                 status,
  output logic [CW-1:0]              element_count
);

  deq_cmd_t cmd;
  deq_sts_t sts;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  deq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .action        (action),
    .data_in       (data_in),
    .position      (position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_data     (read_data),
    .status        (status),
    .element_count (element_count)
  );

endmodule

`default_nettype wire
